// ===== src/itr_pkg.sv =====
// ----------------------------------------------------------------------------
// itr_pkg: shared types and constants for the instruction trace ring
// Field widths, beat codes, controller states and the stored entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package itr_pkg;

   localparam int RING_DEPTH_DEF = 32;

   localparam int CORE_W      = 1;
   localparam int PC_W        = 32;
   localparam int OP_W        = 16;
   localparam int LINES_W     = 6;
   localparam int COUNT_W     = 6;
   localparam int AGE_W       = 5;
   localparam int REQ_DATA_W  = 56;
   localparam int RSP_DATA_W  = 64;

   // request tuser
   localparam logic MODE_RECORD = 1'b0;
   localparam logic MODE_DUMP   = 1'b1;

   // response tuser
   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_ENTRY  = 1'b1;

   typedef struct packed {
      logic [CORE_W-1:0] core;
      logic [PC_W-1:0]   pc;
      logic [OP_W-1:0]   op;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_HEADER,
      ST_WALK_RD,
      ST_WALK_CHK
   } state_type;

endpackage : itr_pkg

`default_nettype wire

// ===== src/itr_ram.sv =====
// ----------------------------------------------------------------------------
// itr_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module itr_ram #(
   parameter int  Width = 8,
   parameter int  Depth = 16,
   localparam int AddrW = $clog2(Depth)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [Width-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : itr_ram

`default_nettype wire

// ===== src/instruction_trace_ring.sv =====
// ----------------------------------------------------------------------------
// instruction_trace_ring: ring of the most recently retired instructions
//
// The req_ channel carries record beats (tuser 0) and dump beats (tuser 1).
// A record beat writes core, pc and opcode at the head, over the oldest
// entry once full, and gives no response; records are taken one per cycle
// while no dump is in progress. A dump beat yields a header beat on rsp_
// (tuser 0) with the match count, or ring_empty set when nothing has been
// recorded, followed by the matching entries oldest first (tuser 1), each
// with its age. tlast marks the final beat of the dump.
// A dump runs in two passes over the storage RAM (none when the ring is empty
// or the line limit is zero): a backward count pass that reads each entry
// (ST_SCAN_RD) and then checks it for a match (ST_SCAN_CHK), then the header,
// then a forward pass that reads and checks those entries again, oldest first.
// req_tready stays low from the dump beat until its last response beat has
// been issued.
// Responses sit in an output register, so a stalled receiver only holds the
// controller at the next beat to be issued; nothing is dropped.
// Reset clears the head, fill count and controller; RAM contents are not
// cleared, as only written slots are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module instruction_trace_ring
   import itr_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // core_id[0], pc[32:1], opcode[48:33], line_limit[54:49], all_cores[55]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // mode[0]
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // matched_count[5:0], ring_empty[6], entry_core[7], entry_pc[39:8],
   // entry_op[55:40], entry_age[60:56], zero[63:61]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // kind[0]
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int IW = CW + 1;

   // request fields
   logic [CORE_W-1:0]  req_core;
   logic [PC_W-1:0]    req_pc;
   logic [OP_W-1:0]    req_op;
   logic [LINES_W-1:0] req_lines;
   logic               req_all;
   logic               req_fire;

   assign req_core  = req_tdata[0];
   assign req_pc    = req_tdata[32:1];
   assign req_op    = req_tdata[48:33];
   assign req_lines = req_tdata[54:49];
   assign req_all   = req_tdata[55];
   assign req_fire  = req_tvalid && req_tready;

   state_type state_ff, state_in;

   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [CORE_W-1:0] core_ff, core_in;
   logic              all_ff, all_in;
   logic              empty_ff, empty_in;
   logic [CW-1:0]     want_ff, want_in;
   logic [CW-1:0]     back_ff, back_in;
   logic [CW-1:0]     matched_ff, matched_in;
   logic [CW-1:0]     walk_ff, walk_in;
   logic [CW-1:0]     emit_ff, emit_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic               wr_en;
   logic [AW-1:0]      rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   entry_type          rd_entry;
   entry_type          wr_entry;

   logic [AW-1:0] scan_idx;
   logic [AW-1:0] walk_idx;
   logic          out_free;
   logic          hit;
   logic [CW-1:0] want_sat;
   logic [AGE_W+CW-1:0] age_wide;

   function automatic logic [AW-1:0] wrap(input logic [IW-1:0] sum);
      logic [IW-1:0] red;
      red = (sum >= IW'(RING_DEPTH)) ? sum - IW'(RING_DEPTH) : sum;
      return red[AW-1:0];
   endfunction

   assign scan_idx = wrap(IW'(head_ff) + IW'(RING_DEPTH - 1) - IW'(back_ff));
   assign walk_idx = wrap(IW'(head_ff) + IW'(RING_DEPTH) - IW'(walk_ff));
   assign rd_addr  = (state_ff == ST_WALK_RD || state_ff == ST_WALK_CHK) ? walk_idx : scan_idx;

   // input is taken only between dumps
   assign req_tready = (state_ff == ST_IDLE);

   assign wr_en    = req_fire && (req_tuser == MODE_RECORD);
   assign wr_entry = '{core: req_core, pc: req_pc, op: req_op};
   assign rd_entry = entry_type'(rd_data);
   assign hit      = all_ff || (rd_entry.core == core_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign want_sat = (int'(req_lines) > RING_DEPTH) ? CW'(RING_DEPTH) : CW'(req_lines);
   assign age_wide = {AGE_W'(0), walk_ff - CW'(1)};

   itr_ram #(
      .Width (ENTRY_W),
      .Depth (RING_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (head_ff),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      core_ff     <= core_in;
      all_ff      <= all_in;
      empty_ff    <= empty_in;
      want_ff     <= want_in;
      back_ff     <= back_in;
      matched_ff  <= matched_in;
      walk_ff     <= walk_in;
      emit_ff     <= emit_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      core_in      = core_ff;
      all_in       = all_ff;
      empty_in     = empty_ff;
      want_in      = want_ff;
      back_in      = back_ff;
      matched_in   = matched_ff;
      walk_in      = walk_ff;
      emit_in      = emit_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == MODE_RECORD) begin
                  head_in = (head_ff == AW'(RING_DEPTH - 1)) ? '0 : head_ff + AW'(1);
                  if (fill_ff != CW'(RING_DEPTH)) begin
                     fill_in = fill_ff + CW'(1);
                  end
               end else begin
                  core_in    = req_core;
                  all_in     = req_all;
                  want_in    = want_sat;
                  back_in    = '0;
                  matched_in = '0;
                  empty_in   = (fill_ff == '0);
                  if (fill_ff == '0 || want_sat == '0) begin
                     state_in = ST_HEADER;
                  end else begin
                     state_in = ST_SCAN_RD;
                  end
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            matched_in = matched_ff + CW'(hit);
            back_in    = back_ff + CW'(1);
            if (back_in == fill_ff || matched_in == want_ff) begin
               state_in = ST_HEADER;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_HEADER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = KIND_HEADER;
               rsp_last_in  = (matched_ff == '0);
               rsp_data_in  = '0;
               rsp_data_in[5:0] = COUNT_W'(matched_ff);
               rsp_data_in[6]   = empty_ff;
               walk_in = back_ff;
               emit_in = '0;
               state_in = (matched_ff == '0) ? ST_IDLE : ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            state_in = ST_WALK_CHK;
         end
         ST_WALK_CHK: begin
            if (!hit) begin
               walk_in  = walk_ff - CW'(1);
               state_in = ST_WALK_RD;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = KIND_ENTRY;
               rsp_last_in  = (emit_ff + CW'(1) == matched_ff);
               rsp_data_in  = '0;
               rsp_data_in[7]     = rd_entry.core;
               rsp_data_in[39:8]  = rd_entry.pc;
               rsp_data_in[55:40] = rd_entry.op;
               rsp_data_in[60:56] = age_wide[AGE_W-1:0];
               emit_in  = emit_ff + CW'(1);
               walk_in  = walk_ff - CW'(1);
               state_in = rsp_last_in ? ST_IDLE : ST_WALK_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // fill count saturates at the ring depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(RING_DEPTH))
      else $error("fill count beyond ring depth");

   // a record always leaves the ring non-empty
   a_fill_after_record: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == MODE_RECORD) |=> (fill_ff != '0))
      else $error("ring empty after a record");

   // never more entry beats than the header announced
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_CHK) |-> (emit_ff < matched_ff))
      else $error("entry beat beyond match count");

   // an empty-ring header ends the dump
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_HEADER && rsp_tdata[6]) |-> rsp_tlast)
      else $error("empty header without tlast");

endmodule : instruction_trace_ring

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the instruction trace ring
// Drives record and dump beats on req_ with random gaps, keeps its own copy
// of the ring to predict each dump's header and entry beats, and checks rsp_
// beats against them in order while the receiver stalls at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import itr_pkg::*;

   localparam int RING_DEPTH     = RING_DEPTH_DEF;
   localparam int RING_AW        = $clog2(RING_DEPTH);
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int IDLE_PCT       = 18;

   typedef struct packed {
      logic               kind;
      logic [COUNT_W-1:0] count;
      logic               empty;
      logic               core;
      logic [PC_W-1:0]    pc;
      logic [OP_W-1:0]    op;
      logic [AGE_W-1:0]   age;
      logic               last;
   } trace_beat_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = MODE_RECORD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   // bench copy of the ring
   entry_type      ring_copy [RING_DEPTH];
   int unsigned    ring_head;
   int unsigned    ring_fill;
   trace_beat_type expected_beats [$];

   int  error_count  = 0;
   int  quiet_cycles = 0;
   bit  no_idle      = 1'b0;

   always #4 clock = ~clock;

   instruction_trace_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   // Updates the ring copy for a record, or queues the beats a dump will give.
   function automatic void apply_trace_item(input logic mode, input logic core_sel,
                                            input logic [PC_W-1:0] pc,
                                            input logic [OP_W-1:0] op,
                                            input logic [LINES_W-1:0] lines,
                                            input logic every_core);
      int unsigned    want, walked, hits, n, idx, i;
      trace_beat_type beat;
      if (mode == MODE_RECORD) begin
         ring_copy[RING_AW'(ring_head)] = '{core: core_sel, pc: pc, op: op};
         ring_head = (ring_head + 1) % RING_DEPTH;
         if (ring_fill < RING_DEPTH)
            ring_fill++;
         return;
      end
      beat = '0;
      beat.kind = KIND_HEADER;
      if (ring_fill == 0) begin
         beat.empty = 1'b1;
         beat.last  = 1'b1;
         expected_beats.push_back(beat);
         return;
      end
      want   = (lines > RING_DEPTH) ? RING_DEPTH : lines;
      walked = 0;
      hits   = 0;
      // count pass: back from the newest until enough matches are found
      while (walked < ring_fill && hits < want) begin
         idx = (ring_head + RING_DEPTH - 1 - walked) % RING_DEPTH;
         if (every_core || ring_copy[RING_AW'(idx)].core == core_sel)
            hits++;
         walked++;
      end
      beat.count = COUNT_W'(hits);
      beat.last  = (hits == 0);
      expected_beats.push_back(beat);
      n = 1;
      for (i = walked; i > 0; i--) begin
         idx = (ring_head + RING_DEPTH - i) % RING_DEPTH;
         if (every_core || ring_copy[RING_AW'(idx)].core == core_sel) begin
            beat      = '0;
            beat.kind = KIND_ENTRY;
            beat.core = ring_copy[RING_AW'(idx)].core;
            beat.pc   = ring_copy[RING_AW'(idx)].pc;
            beat.op   = ring_copy[RING_AW'(idx)].op;
            beat.age  = AGE_W'(i - 1);
            beat.last = (n == hits);
            expected_beats.push_back(beat);
            n++;
         end
      end
   endfunction

   task automatic send_item(input logic mode, input logic core_sel,
                            input logic [PC_W-1:0] pc, input logic [OP_W-1:0] op,
                            input logic [LINES_W-1:0] lines, input logic every_core);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {every_core, lines, op, pc, core_sel};
      do
         @(posedge clock);
      while (!req_tready);
      apply_trace_item(mode, core_sel, pc, op, lines, every_core);
   endtask

   // dump beats carry random pc and opcode, which the block must ignore
   task automatic send_record(input logic core_sel, input logic [PC_W-1:0] pc,
                              input logic [OP_W-1:0] op);
      send_item(MODE_RECORD, core_sel, pc, op, LINES_W'($urandom), 1'($urandom));
   endtask

   task automatic send_dump(input logic core_sel, input logic [LINES_W-1:0] lines,
                            input logic every_core);
      send_item(MODE_DUMP, core_sel, PC_W'($urandom), OP_W'($urandom), lines,
                every_core);
   endtask

   task automatic test_empty_dump;
      send_dump(1'b0, 6'd0, 1'b0);
      send_dump(1'b1, 6'd63, 1'b1);
   endtask

   task automatic test_no_match;
      send_record(1'b0, 32'h0000_1000, 16'h1234);
      send_record(1'b0, 32'h0000_1002, 16'h5678);
      send_dump(1'b1, 6'd5, 1'b0);
      send_dump(1'b0, 6'd0, 1'b1);
   endtask

   task automatic test_record_extremes;
      send_record(1'b0, 32'h0000_0000, 16'h0000);
      send_record(1'b1, 32'hFFFF_FFFF, 16'hFFFF);
      send_record(1'b1, 32'h5555_5555, 16'hAAAA);
      send_record(1'b0, 32'hAAAA_AAAA, 16'h5555);
      send_dump(1'b0, 6'd3, 1'b1);
      send_dump(1'b1, 6'd63, 1'b0);
      send_dump(1'b0, 6'd32, 1'b0);
      send_dump(1'b1, 6'd1, 1'b0);
   endtask

   // back-to-back records past one full turn of the ring, no stalls
   task automatic test_wrap_burst;
      int k;
      no_idle = 1'b1;
      for (k = 0; k < RING_DEPTH + 8; k++)
         send_record(1'($urandom), $urandom, OP_W'($urandom));
      send_dump(1'b0, 6'd32, 1'b1);
      send_dump(1'($urandom), 6'd63, 1'b0);
      send_dump(1'b1, 6'd33, 1'b1);
      no_idle = 1'b0;
   endtask

   task automatic test_random_traffic;
      int              k;
      logic [LINES_W-1:0] lines;
      for (k = 0; k < 140; k++) begin
         if ($urandom_range(99) < 12) begin
            // mostly short dumps, the rest with a random line limit up to 63
            lines = ($urandom_range(99) < 60) ? LINES_W'($urandom_range(0, 8))
                                             : LINES_W'($urandom);
            send_dump(1'($urandom), lines, 1'($urandom));
         end else begin
            send_record(1'($urandom), $urandom, OP_W'($urandom));
         end
      end
   endtask

   always @(posedge clock)
      rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

   always @(posedge clock) begin : rsp_check
      trace_beat_type seen, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.kind  = rsp_tuser;
         seen.count = rsp_tdata[5:0];
         seen.empty = rsp_tdata[6];
         seen.core  = rsp_tdata[7];
         seen.pc    = rsp_tdata[39:8];
         seen.op    = rsp_tdata[55:40];
         seen.age   = rsp_tdata[60:56];
         seen.last  = rsp_tlast;
         if (expected_beats.size() == 0) begin
            report_mismatch("beat with nothing expected", rsp_tdata, '0);
         end else begin
            want = expected_beats.pop_front();
            if (seen.kind != want.kind)
               report_mismatch("kind", 64'(seen.kind), 64'(want.kind));
            if (seen.count != want.count)
               report_mismatch("matched_count", 64'(seen.count), 64'(want.count));
            if (seen.empty != want.empty)
               report_mismatch("ring_empty", 64'(seen.empty), 64'(want.empty));
            if (seen.core != want.core)
               report_mismatch("entry_core", 64'(seen.core), 64'(want.core));
            if (seen.pc != want.pc)
               report_mismatch("entry_pc", 64'(seen.pc), 64'(want.pc));
            if (seen.op != want.op)
               report_mismatch("entry_op", 64'(seen.op), 64'(want.op));
            if (seen.age != want.age)
               report_mismatch("entry_age", 64'(seen.age), 64'(want.age));
            if (seen.last != want.last)
               report_mismatch("last", 64'(seen.last), 64'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   initial begin
      ring_head = 0;
      ring_fill = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_dump();
      test_no_match();
      test_record_extremes();
      test_wrap_burst();
      test_random_traffic();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0)
         @(posedge clock);
      // catch any stray beats after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule : tb_top

`default_nettype wire
